>>> sv/tpv_pkg.sv
// ----------------------------------------------------------------------------
// tpv_pkg
// Shared widths, constants and beat types of the triangle prism volume unit.
// ----------------------------------------------------------------------------
package tpv_pkg;

  // Coordinate format: signed Q11.12.
  localparam int COORD_W   = 24;
  localparam int FRAC_W    = 12;
  localparam int AREA_W    = 40;
  localparam int VOL_W     = 49;

  // Edge vectors, their products and the cross product.
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int CROSS_W   = PROD_W;
  localparam int MAG_W     = CROSS_W - 1;
  localparam int LO_W      = MAG_W / 2;
  localparam int HI_W      = MAG_W - LO_W;

  // Squared cross product and the radicand handed to the root units.
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int SQ_SHIFT  = 2 * FRAC_W + 2;
  localparam int VAL_W     = SUM_W - SQ_SHIFT;
  localparam int ROOT_W    = (VAL_W + 1) / 2;

  // Centroid and depth below the waterline.
  localparam int ZSUM_W    = COORD_W + 2;
  localparam int DEPTH_W   = ZSUM_W + 1;
  localparam int CENT_SHIFT = ZSUM_W + 1;
  localparam int CENT_MUL  = ((1 << CENT_SHIFT) + 2) / 3;
  localparam int CENT_OFS  = 3 * (1 << (COORD_W - 1));

  // Volume product and the divide by three.
  localparam int VPROD_W   = MAG_W + ZSUM_W;
  localparam int VOL_SHIFT = 2 * FRAC_W + 1;
  localparam int VQ_W      = VPROD_W - VOL_SHIFT;
  localparam int DIV_CHUNK = 8;
  localparam int DIV_STAGES = (VQ_W + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int DIV_PAD_W = DIV_STAGES * DIV_CHUNK;
  localparam int DIV_CUR_W = DIV_CHUNK + 2;
  localparam int DIV_SHIFT = DIV_CUR_W + 1;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + 2) / 3;

  // Pipeline depths.
  localparam int GEOM_STAGES  = 7;
  localparam int SQRT_STAGES  = ROOT_W;
  localparam int ALIGN_STAGES = SQRT_STAGES - DIV_STAGES;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
  } panel_t;

  typedef struct packed {
    logic [AREA_W-1:0]         surface_area;
    logic [AREA_W-1:0]         plan_area;
    logic [VOL_W-1:0]          prism_volume;
    logic signed [COORD_W-1:0] centroid_height;
    logic                      dry_flag;
    logic                      degenerate_flag;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] centroid;
    logic                      dry;
    logic                      degen;
  } side_t;

  typedef struct packed {
    logic [VOL_W-1:0] volume;
    side_t            side;
  } track_t;

endpackage

>>> sv/tpv_geom.sv
// ----------------------------------------------------------------------------
// tpv_geom
// Edge vectors, cross product, squared lengths, centroid and volume numerator.
// ----------------------------------------------------------------------------
module tpv_geom import tpv_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      item_valid,
  input  panel_t                    panel,
  input  logic signed [COORD_W-1:0] waterline,
  output logic                      stage_valid,
  output logic [VAL_W-1:0]          area_sq,
  output logic [VAL_W-1:0]          plan_sq,
  output logic [VQ_W-1:0]           vol_num,
  output side_t                     side
);

  logic [GEOM_STAGES-1:0] vld;

  // Stage 1
  logic signed [DIFF_W-1:0] s1_u [3];
  logic signed [DIFF_W-1:0] s1_w [3];
  logic signed [ZSUM_W-1:0] s1_zsum;
  logic                     s1_degen;
  // Stage 2
  logic signed [PROD_W-1:0] s2_pa, s2_pb, s2_pc, s2_pd, s2_pe, s2_pf;
  logic [ZSUM_W-1:0]        s2_t;
  logic [ZSUM_W-1:0]        s2_dmag;
  logic                     s2_dry, s2_degen;
  // Stage 3
  logic signed [CROSS_W-1:0] s3_cx, s3_cy, s3_cz;
  logic [2*ZSUM_W-1:0]       s3_cprod;
  logic [ZSUM_W-1:0]         s3_dmag;
  logic                      s3_dry, s3_degen;
  // Stage 4
  logic [MAG_W-1:0]  s4_mx, s4_my, s4_mz;
  logic [ZSUM_W-1:0] s4_dmag;
  side_t             s4_side;
  // Stage 5
  logic [2*HI_W-1:0]       s5_hhx, s5_hhy, s5_hhz;
  logic [HI_W+LO_W-1:0]    s5_hlx, s5_hly, s5_hlz;
  logic [2*LO_W-1:0]       s5_llx, s5_lly, s5_llz;
  logic [HI_W+ZSUM_W-1:0]  s5_vh;
  logic [LO_W+ZSUM_W-1:0]  s5_vl;
  side_t                   s5_side;
  // Stage 6
  logic [SQ_W-1:0]    s6_sqx, s6_sqy, s6_sqz;
  logic [VPROD_W-1:0] s6_vprod;
  side_t              s6_side;
  // Stage 7
  logic [SUM_W-1:0]   s7_sum;
  logic [SQ_W-1:0]    s7_sqz;
  logic [VQ_W-1:0]    s7_vol;
  side_t              s7_side;

  logic                      degen;
  logic signed [DEPTH_W-1:0] depth;

  always_comb begin
    degen = (panel.v0_x == panel.v1_x && panel.v0_y == panel.v1_y &&
             panel.v0_z == panel.v1_z) ||
            (panel.v0_x == panel.v2_x && panel.v0_y == panel.v2_y &&
             panel.v0_z == panel.v2_z) ||
            (panel.v1_x == panel.v2_x && panel.v1_y == panel.v2_y &&
             panel.v1_z == panel.v2_z);
    // Three times the waterline minus the z sum; negative means dry.
    depth = DEPTH_W'(waterline) + (DEPTH_W'(waterline) <<< 1) - DEPTH_W'(s1_zsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[GEOM_STAGES-2:0], item_valid};
    end
  end

  function automatic logic [SQ_W-1:0] square_sum(
    input logic [2*HI_W-1:0]    hh,
    input logic [HI_W+LO_W-1:0] hl,
    input logic [2*LO_W-1:0]    ll
  );
    square_sum = (SQ_W'(hh) << (2 * LO_W)) + (SQ_W'(hl) << (LO_W + 1)) + SQ_W'(ll);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: edge vectors from the first vertex.
      s1_u[0]  <= DIFF_W'(panel.v1_x) - DIFF_W'(panel.v0_x);
      s1_u[1]  <= DIFF_W'(panel.v1_y) - DIFF_W'(panel.v0_y);
      s1_u[2]  <= DIFF_W'(panel.v1_z) - DIFF_W'(panel.v0_z);
      s1_w[0]  <= DIFF_W'(panel.v2_x) - DIFF_W'(panel.v0_x);
      s1_w[1]  <= DIFF_W'(panel.v2_y) - DIFF_W'(panel.v0_y);
      s1_w[2]  <= DIFF_W'(panel.v2_z) - DIFF_W'(panel.v0_z);
      s1_zsum  <= ZSUM_W'(panel.v0_z) + ZSUM_W'(panel.v1_z) + ZSUM_W'(panel.v2_z);
      s1_degen <= degen;

      // Stage 2: cross product terms, depth, offset z sum.
      s2_pa    <= s1_u[1] * s1_w[2];
      s2_pb    <= s1_u[2] * s1_w[1];
      s2_pc    <= s1_u[2] * s1_w[0];
      s2_pd    <= s1_u[0] * s1_w[2];
      s2_pe    <= s1_u[0] * s1_w[1];
      s2_pf    <= s1_u[1] * s1_w[0];
      // The offset makes the sum non-negative so that floor division is a
      // plain reciprocal multiply.
      s2_t     <= ZSUM_W'(s1_zsum) + ZSUM_W'(CENT_OFS);
      s2_dry   <= depth[DEPTH_W-1];
      s2_dmag  <= depth[DEPTH_W-2:0];
      s2_degen <= s1_degen;

      // Stage 3
      s3_cx    <= s2_pa - s2_pb;
      s3_cy    <= s2_pc - s2_pd;
      s3_cz    <= s2_pe - s2_pf;
      s3_cprod <= (2*ZSUM_W)'(s2_t) * (2*ZSUM_W)'(CENT_MUL);
      s3_dmag  <= s2_dmag;
      s3_dry   <= s2_dry;
      s3_degen <= s2_degen;

      // Stage 4: magnitudes; removing the offset flips the top bit.
      s4_mx <= s3_cx[CROSS_W-1] ? MAG_W'(-s3_cx) : MAG_W'(s3_cx);
      s4_my <= s3_cy[CROSS_W-1] ? MAG_W'(-s3_cy) : MAG_W'(s3_cy);
      s4_mz <= s3_cz[CROSS_W-1] ? MAG_W'(-s3_cz) : MAG_W'(s3_cz);
      s4_dmag <= s3_dmag;
      s4_side.centroid <= {~s3_cprod[CENT_SHIFT+COORD_W-1],
                           s3_cprod[CENT_SHIFT+COORD_W-2:CENT_SHIFT]};
      s4_side.dry      <= s3_dry;
      s4_side.degen    <= s3_degen;

      // Stage 5: partial products of the squares and of the volume.
      s5_hhx <= s4_mx[MAG_W-1:LO_W] * s4_mx[MAG_W-1:LO_W];
      s5_hly <= s4_my[MAG_W-1:LO_W] * s4_my[LO_W-1:0];
      s5_hlx <= s4_mx[MAG_W-1:LO_W] * s4_mx[LO_W-1:0];
      s5_llx <= s4_mx[LO_W-1:0] * s4_mx[LO_W-1:0];
      s5_hhy <= s4_my[MAG_W-1:LO_W] * s4_my[MAG_W-1:LO_W];
      s5_lly <= s4_my[LO_W-1:0] * s4_my[LO_W-1:0];
      s5_hhz <= s4_mz[MAG_W-1:LO_W] * s4_mz[MAG_W-1:LO_W];
      s5_hlz <= s4_mz[MAG_W-1:LO_W] * s4_mz[LO_W-1:0];
      s5_llz <= s4_mz[LO_W-1:0] * s4_mz[LO_W-1:0];
      s5_vh  <= s4_mz[MAG_W-1:LO_W] * s4_dmag;
      s5_vl  <= s4_mz[LO_W-1:0] * s4_dmag;
      s5_side <= s4_side;

      // Stage 6
      s6_sqx   <= square_sum(s5_hhx, s5_hlx, s5_llx);
      s6_sqy   <= square_sum(s5_hhy, s5_hly, s5_lly);
      s6_sqz   <= square_sum(s5_hhz, s5_hlz, s5_llz);
      s6_vprod <= (VPROD_W'(s5_vh) << LO_W) + VPROD_W'(s5_vl);
      s6_side  <= s5_side;

      // Stage 7
      s7_sum  <= SUM_W'(s6_sqx) + SUM_W'(s6_sqy) + SUM_W'(s6_sqz);
      s7_sqz  <= s6_sqz;
      s7_vol  <= s6_side.dry ? '0 : s6_vprod[VPROD_W-1:VOL_SHIFT];
      s7_side <= s6_side;
    end
  end

  assign stage_valid = vld[GEOM_STAGES-1];
  assign area_sq     = s7_sum[SUM_W-1:SQ_SHIFT];
  assign plan_sq     = VAL_W'(s7_sqz[SQ_W-1:SQ_SHIFT]);
  assign vol_num     = s7_vol;
  assign side        = s7_side;

endmodule

>>> sv/tpv_sqrt.sv
// ----------------------------------------------------------------------------
// tpv_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module tpv_sqrt import tpv_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [VAL_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  logic [VAL_W-1:0] xs [SQRT_STAGES];
  logic [VAL_W-1:0] rs [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [VAL_W:0] BIT = {{VAL_W{1'b0}}, 1'b1} << (2 * (SQRT_STAGES - 1 - k));
    logic [VAL_W-1:0] x_in;
    logic [VAL_W-1:0] r_in;
    logic [VAL_W:0]   trial;

    if (k == 0) begin : g_first
      assign x_in = radicand;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = xs[k-1];
      assign r_in = rs[k-1];
    end

    assign trial = {1'b0, r_in} + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, x_in} >= trial) begin
          xs[k] <= VAL_W'({1'b0, x_in} - trial);
          rs[k] <= VAL_W'({2'b0, r_in[VAL_W-1:1]} + BIT);
        end else begin
          xs[k] <= x_in;
          rs[k] <= {1'b0, r_in[VAL_W-1:1]};
        end
      end
    end
  end

  assign root = rs[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

>>> sv/tpv_div3.sv
// ----------------------------------------------------------------------------
// tpv_div3
// Pipelined floor division by three, one byte of quotient per stage.
// ----------------------------------------------------------------------------
module tpv_div3 import tpv_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            num_valid,
  input  logic [VQ_W-1:0] num,
  input  side_t           side,
  output logic            quot_valid,
  output track_t          quot
);

  // Each stage replaces its byte of the numerator by the quotient byte.
  logic [DIV_PAD_W-1:0]  word [DIV_STAGES];
  logic [1:0]            rem  [DIV_STAGES];
  side_t                 info [DIV_STAGES];
  logic [DIV_STAGES-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STAGES-2:0], num_valid};
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int POS = DIV_PAD_W - 1 - DIV_CHUNK * k;
    logic [DIV_PAD_W-1:0]   word_in;
    logic [1:0]             rem_in;
    side_t                  info_in;
    logic [DIV_CUR_W-1:0]   cur;
    logic [2*DIV_CUR_W-1:0] prod;
    logic [DIV_CHUNK-1:0]   qd;
    logic [DIV_CUR_W-1:0]   back;
    logic [DIV_PAD_W-1:0]   word_next;

    if (k == 0) begin : g_first
      assign word_in = DIV_PAD_W'(num);
      assign rem_in  = '0;
      assign info_in = side;
    end else begin : g_next
      assign word_in = word[k-1];
      assign rem_in  = rem[k-1];
      assign info_in = info[k-1];
    end

    always_comb begin
      cur       = {rem_in, word_in[POS -: DIV_CHUNK]};
      prod      = (2*DIV_CUR_W)'(cur) * (2*DIV_CUR_W)'(DIV_MUL);
      qd        = prod[DIV_SHIFT +: DIV_CHUNK];
      back      = {1'b0, qd, 1'b0} + DIV_CUR_W'(qd);
      word_next = word_in;
      word_next[POS -: DIV_CHUNK] = qd;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        word[k] <= word_next;
        rem[k]  <= 2'(cur - back);
        info[k] <= info_in;
      end
    end
  end

  assign quot_valid  = vld[DIV_STAGES-1];
  assign quot.volume = word[DIV_STAGES-1][VOL_W-1:0];
  assign quot.side   = info[DIV_STAGES-1];

endmodule

>>> sv/triangle_prism_volume_unit.sv
// ----------------------------------------------------------------------------
// triangle_prism_volume_unit
// Panel areas from the cross product, centroid height and prism volume below a waterline.
// ----------------------------------------------------------------------------
// Pipeline: 7 geometry stages, 37 square-root stages and 1 output register
// lie between an accepted panel beat and its result beat.
// Throughput: one panel per cycle when not stalled; the roots set the depth.
// A stalled result holds the whole pipeline; nothing is dropped.
// Reset clears all valid bits and sets the waterline to zero.
// ----------------------------------------------------------------------------
module triangle_prism_volume_unit import tpv_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      panel_valid,
  output logic                      panel_stall,
  input  panel_t                    panel,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result,
  input  logic                      cfg_we,
  input  logic signed [COORD_W-1:0] cfg_data
);

  logic signed [COORD_W-1:0] waterline;
  logic                      en;

  logic              geom_valid;
  logic [VAL_W-1:0]  area_sq;
  logic [VAL_W-1:0]  plan_sq;
  logic [VQ_W-1:0]   vol_num;
  side_t             geom_side;

  logic [ROOT_W-1:0] area_root;
  logic [ROOT_W-1:0] plan_root;

  logic              quot_valid;
  track_t            quot;

  track_t                  align [ALIGN_STAGES];
  logic [ALIGN_STAGES-1:0] align_valid;

  assign en          = !(result_valid && result_stall);
  assign panel_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      waterline <= '0;
    end else if (cfg_we) begin
      waterline <= cfg_data;
    end
  end

  tpv_geom u_geom (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .item_valid  (panel_valid),
    .panel       (panel),
    .waterline   (waterline),
    .stage_valid (geom_valid),
    .area_sq     (area_sq),
    .plan_sq     (plan_sq),
    .vol_num     (vol_num),
    .side        (geom_side)
  );

  tpv_sqrt u_area_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (area_sq),
    .root     (area_root)
  );

  tpv_sqrt u_plan_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (plan_sq),
    .root     (plan_root)
  );

  tpv_div3 u_div3 (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .num_valid  (geom_valid),
    .num        (vol_num),
    .side       (geom_side),
    .quot_valid (quot_valid),
    .quot       (quot)
  );

  // Delay the volume and side fields to line up with the roots.
  always_ff @(posedge clk) begin
    if (rst) begin
      align_valid <= '0;
    end else if (en) begin
      align_valid <= {align_valid[ALIGN_STAGES-2:0], quot_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      align[0] <= quot;
      for (int i = 1; i < ALIGN_STAGES; i++) begin
        align[i] <= align[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= align_valid[ALIGN_STAGES-1];
    end
  end

  // The radicands are too narrow for the roots ever to need saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      result.surface_area    <= AREA_W'(area_root);
      result.plan_area       <= AREA_W'(plan_root);
      result.prism_volume    <= align[ALIGN_STAGES-1].volume;
      result.centroid_height <= align[ALIGN_STAGES-1].side.centroid;
      result.dry_flag        <= align[ALIGN_STAGES-1].side.dry;
      result.degenerate_flag <= align[ALIGN_STAGES-1].side.degen;
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triangle prism volume unit: a directed table of
// panels, then random panels over several waterline settings, with bursty
// input beats and a patterned result stall. Every result beat is checked
// against an exact integer model of the geometry or a listed expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tpv_pkg::*;

  localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] CMIN = 24'sh800000;
  localparam int NDIR  = 14;
  localparam int DRAIN = 60;

  logic                      clk;
  logic                      rst;
  logic                      panel_valid;
  logic                      panel_stall;
  panel_t                    panel;
  logic                      result_valid;
  logic                      result_stall;
  result_t                   result;
  logic                      cfg_we;
  logic signed [COORD_W-1:0] cfg_data;

  result_t                   pending_q[$];
  logic signed [COORD_W-1:0] cur_wl;
  int                        mismatches;
  int                        burst_left;
  int                        stall_cnt;

  triangle_prism_volume_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .panel_valid  (panel_valid),
    .panel_stall  (panel_stall),
    .panel        (panel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Floor of the square root of a radicand, saturated to the area width.
  function automatic logic [AREA_W-1:0] floor_root(logic [127:0] val);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    if ((val >> (2 * AREA_W)) != 0) return '1;
    for (int b = AREA_W - 1; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= val) r = t;
    end
    return r[AREA_W-1:0];
  endfunction

  function automatic result_t panel_geometry(panel_t p, logic signed [COORD_W-1:0] wl);
    result_t             res;
    logic signed [127:0] ux, uy, uz, vx, vy, vz, cx, cy, cz, s, d, q, mag, prod;
    logic signed [127:0] wl_w;
    ux = p.v1_x - p.v0_x;
    uy = p.v1_y - p.v0_y;
    uz = p.v1_z - p.v0_z;
    vx = p.v2_x - p.v0_x;
    vy = p.v2_y - p.v0_y;
    vz = p.v2_z - p.v0_z;
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    res.surface_area = floor_root((cx * cx + cy * cy + cz * cz) >> SQ_SHIFT);
    res.plan_area    = floor_root((cz * cz) >> SQ_SHIFT);
    s = p.v0_z;
    s = s + p.v1_z + p.v2_z;
    // Centroid rounds toward minus infinity.
    q = (s >= 0) ? s / 3 : -((-s + 2) / 3);
    res.centroid_height = q[COORD_W-1:0];
    wl_w = wl;
    d = 3 * wl_w - s;
    res.dry_flag = (d < 0);
    res.prism_volume = '0;
    if (d >= 0) begin
      mag  = (cz < 0) ? -cz : cz;
      prod = ((mag * d) >>> VOL_SHIFT) / 3;
      res.prism_volume = ((prod >> VOL_W) != 0) ? '1 : prod[VOL_W-1:0];
    end
    res.degenerate_flag =
      ({p.v0_x, p.v0_y, p.v0_z} == {p.v1_x, p.v1_y, p.v1_z}) ||
      ({p.v0_x, p.v0_y, p.v0_z} == {p.v2_x, p.v2_y, p.v2_z}) ||
      ({p.v1_x, p.v1_y, p.v1_z} == {p.v2_x, p.v2_y, p.v2_z});
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(int kind);
    logic signed [COORD_W-1:0] c;
    case (kind)
      0: begin
        c = COORD_W'($urandom);
      end
      1: begin
        c = COORD_W'($urandom_range(0, 8191));
        c = c - 24'sd4096;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: c = CMAX;
          1: c = CMIN;
          2: c = '0;
          default: c = '1;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic panel_t random_panel(logic signed [COORD_W-1:0] wl);
    panel_t p;
    int     kind;
    logic signed [COORD_W-1:0] c[9];
    kind = $urandom_range(0, 7);
    for (int i = 0; i < 9; i++) begin
      c[i] = pick_coord(kind < 3 ? 0 : (kind < 7 ? 1 : 2));
    end
    // Keep some centroids right around the waterline.
    if ($urandom_range(0, 7) == 0) begin
      c[2] = wl + COORD_W'($urandom_range(0, 4)) - 24'sd2;
      c[5] = wl + COORD_W'($urandom_range(0, 4)) - 24'sd2;
      c[8] = wl + COORD_W'($urandom_range(0, 4)) - 24'sd2;
    end
    p = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
    case ($urandom_range(0, 11))
      0: {p.v1_x, p.v1_y, p.v1_z} = {p.v0_x, p.v0_y, p.v0_z};
      1: {p.v2_x, p.v2_y, p.v2_z} = {p.v1_x, p.v1_y, p.v1_z};
      default: ;
    endcase
    return p;
  endfunction

  // Drive one panel beat, with burst gaps in front of it, and log its result.
  task automatic send_panel(panel_t p, bit typed, result_t want);
    result_t exp_beat;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(0, 6)) begin
        @(negedge clk);
        panel_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    panel_valid <= 1'b1;
    panel       <= p;
    do @(posedge clk); while (panel_stall);
    exp_beat  = typed ? want : panel_geometry(p, cur_wl);
    pending_q = {pending_q, exp_beat};
  endtask

  task automatic drain_and_write(logic signed [COORD_W-1:0] wl);
    @(negedge clk);
    panel_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= wl;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_wl = wl;
  endtask

  // Receiver: stretches of no stall, light and heavy random and on-off stall.
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    case (stall_cnt[7:6])
      2'd0:    result_stall <= 1'b0;
      2'd1:    result_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= stall_cnt[2];
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %h", result);
      end else begin
        want = pending_q.pop_front();
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: surface %h/%h plan %h/%h volume %h/%h",
                     want.surface_area, result.surface_area,
                     want.plan_area, result.plan_area,
                     want.prism_volume, result.prism_volume);
            $display("  centroid %h/%h dry %b/%b degenerate %b/%b (expected/actual)",
                     want.centroid_height, result.centroid_height,
                     want.dry_flag, result.dry_flag,
                     want.degenerate_flag, result.degenerate_flag);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    panel_t                    dir_panel[NDIR];
    result_t                   dir_want[NDIR];
    bit                        dir_typed[NDIR];
    logic signed [COORD_W-1:0] wl_list[4];
    rst          = 1'b1;
    panel_valid  = 1'b0;
    panel        = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    cur_wl       = '0;
    mismatches   = 0;
    burst_left   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_typed[i]) begin
      dir_typed[i] = 1'b0;
      dir_want[i]  = '0;
    end
    // All vertices at origin: degenerate, else all zero, centroid at waterline.
    dir_panel[0] = '0;
    dir_typed[0] = 1'b1;
    dir_want[0]  = '{default: '0, degenerate_flag: 1'b1};
    // All vertices at the top corner: collapsed and dry.
    dir_panel[1] = {9{CMAX}};
    dir_typed[1] = 1'b1;
    dir_want[1]  = '{default: '0, centroid_height: CMAX, dry_flag: 1'b1,
                     degenerate_flag: 1'b1};
    // All vertices at the bottom corner: collapsed and wet, zero volume.
    dir_panel[2] = {9{CMIN}};
    dir_typed[2] = 1'b1;
    dir_want[2]  = '{default: '0, centroid_height: CMIN, degenerate_flag: 1'b1};
    dir_panel[3]  = {24'sd0, 24'sd0, 24'sd0, CMAX, 24'sd0, 24'sd0, 24'sd0, CMAX, 24'sd0};
    dir_panel[4]  = {CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN};
    dir_panel[5]  = {CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN};
    dir_panel[6]  = {CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN};
    // Two equal vertices with a distinct third one.
    dir_panel[7]  = {24'sd100, 24'sd7, -24'sd3, 24'sd100, 24'sd7, -24'sd3,
                     24'sd9, 24'sd55, 24'sd1};
    // Vertical panel: plan area zero, surface area not.
    dir_panel[8]  = {24'sd0, 24'sd0, -24'sd4096, 24'sd4096, 24'sd4096, -24'sd4096,
                     24'sd0, 24'sd0, 24'sd4096};
    // Centroid just above, just below and exactly on the waterline.
    dir_panel[9]  = {24'sd0, 24'sd0, 24'sd1, 24'sd4096, 24'sd0, 24'sd0,
                     24'sd0, 24'sd4096, 24'sd0};
    dir_panel[10] = {24'sd0, 24'sd0, -24'sd1, 24'sd4096, 24'sd0, 24'sd0,
                     24'sd0, 24'sd4096, 24'sd0};
    dir_panel[11] = {24'sd0, 24'sd0, -24'sd1, 24'sd4096, 24'sd0, 24'sd1,
                     24'sd0, 24'sd4096, 24'sd0};
    dir_panel[12] = {24'sd1, 24'sd0, CMIN, 24'sd0, 24'sd1, CMIN, -24'sd1, -24'sd1, CMIN};
    dir_panel[13] = {CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 24'sd0, -24'sd1, 24'sd5};

    for (int i = 0; i < NDIR; i++) send_panel(dir_panel[i], dir_typed[i], dir_want[i]);

    wl_list[0] = CMIN;
    wl_list[1] = CMAX;
    wl_list[2] = COORD_W'($urandom);
    wl_list[3] = COORD_W'($urandom_range(0, 65535)) - 24'sd32768;
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_write(wl_list[ph]);
      for (int n = 0; n < 400; n++) begin
        // Once per phase, hold off until the pipeline has emptied.
        if (n == 200) begin
          @(negedge clk);
          panel_valid <= 1'b0;
          wait (pending_q.size() == 0);
        end
        send_panel(random_panel(cur_wl), 1'b0, '0);
      end
    end
    // Back to the reset value for a short final stretch.
    drain_and_write('0);
    for (int n = 0; n < 50; n++) send_panel(random_panel(cur_wl), 1'b0, '0);

    @(negedge clk);
    panel_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/tpv_pkg.sv
sv/tpv_geom.sv
sv/tpv_sqrt.sv
sv/tpv_div3.sv
sv/triangle_prism_volume_unit.sv
tb/tb.sv
